/* design/fsp_pkg.sv */
// Shared types, character codes and helper functions for the format specifier parser.
package fsp_pkg;

    // Accumulator width for width and precision values
    localparam int NUM_WIDTH = 16;
    // Reported value width
    localparam int OUT_W = 16;
    // Common width for clipping an accumulator to the reported range
    localparam int CLIP_W = (NUM_WIDTH > OUT_W) ? NUM_WIDTH : OUT_W;
    localparam logic [OUT_W-1:0] OUT_MAX = '1;

    // Character codes
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_H     = 8'h68;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_J     = 8'h6A;
    localparam logic [7:0] CH_Z     = 8'h7A;
    localparam logic [7:0] CH_T     = 8'h74;

    // Length modifier codes
    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN_HH   = 3'd1;
    localparam logic [2:0] LEN_H    = 3'd2;
    localparam logic [2:0] LEN_LL   = 3'd3;
    localparam logic [2:0] LEN_L    = 3'd4;
    localparam logic [2:0] LEN_J    = 3'd5;
    localparam logic [2:0] LEN_Z    = 3'd6;
    localparam logic [2:0] LEN_T    = 3'd7;

    // Flag bit positions
    localparam int FLG_MINUS = 0;
    localparam int FLG_PLUS  = 1;
    localparam int FLG_SPACE = 2;
    localparam int FLG_HASH  = 3;
    localparam int FLG_ZERO  = 4;

    typedef enum logic [2:0] {
        PH_IDLE        = 3'd0,
        PH_FLAGS       = 3'd1,
        PH_WIDTH       = 3'd2,
        PH_PREC_FIRST  = 3'd3,
        PH_PREC_DIGITS = 3'd4,
        PH_SKIP        = 3'd5,
        PH_H_PEND      = 3'd6,
        PH_L_PEND      = 3'd7
    } phase_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       start_spec;
    } in_t;

    typedef struct packed {
        logic             left_align;
        logic             force_sign;
        logic             space_sign;
        logic             alt_form;
        logic             zero_pad;
        logic [OUT_W-1:0] field_width;
        logic             width_from_arg;
        logic             has_precision;
        logic [OUT_W-1:0] precision_value;
        logic             precision_from_arg;
        logic [2:0]       length_code;
        logic [OUT_W-1:0] chars_consumed;
    } out_t;

    // Star and dot marks
    typedef struct packed {
        logic pstar;
        logic dot;
        logic wstar;
    } sd_t;

    // Parser state carried between characters
    typedef struct packed {
        phase_t               phase;
        logic [4:0]           flags;
        logic [NUM_WIDTH-1:0] width_acc;
        logic [NUM_WIDTH-1:0] prec_acc;
        sd_t                  sd;
        logic [OUT_W-1:0]     count;
    } state_t;

    // Multiply by ten, add a digit, saturate at the accumulator maximum
    function automatic logic [NUM_WIDTH-1:0] acc_digit(input logic [NUM_WIDTH-1:0] acc,
                                                       input logic [7:0] c);
        logic [NUM_WIDTH+3:0] wide;
        logic [NUM_WIDTH+3:0] sum;
        wide = {4'b0000, acc};
        sum  = (wide << 3) + (wide << 1) + (NUM_WIDTH+4)'(c[3:0]);
        if (sum[NUM_WIDTH+3:NUM_WIDTH] != 4'b0000)
            return '1;
        else
            return sum[NUM_WIDTH-1:0];
    endfunction

    // Clip an accumulator to the reported range
    function automatic logic [OUT_W-1:0] clip_num(input logic [NUM_WIDTH-1:0] v);
        logic [CLIP_W-1:0] ext;
        ext = CLIP_W'(v);
        if (ext > CLIP_W'(OUT_MAX))
            return OUT_MAX;
        else
            return ext[OUT_W-1:0];
    endfunction

endpackage

/* design/fsp_step.sv */
// Combinational next-state and result logic for one character.
module fsp_step (
    input  fsp_pkg::state_t cur,
    input  fsp_pkg::in_t    din,
    output fsp_pkg::state_t nxt,
    output logic            emit,
    output fsp_pkg::out_t   res
);
    import fsp_pkg::*;

    logic [7:0] c;
    logic       is_dig;
    logic       is_star;
    logic       is_dot;
    logic       is_flag;
    logic       do_len;
    logic       do_consume;
    logic [2:0] len;
    state_t     s;

    assign c       = din.ch;
    assign is_dig  = (c >= CH_ZERO) && (c <= CH_NINE);
    assign is_star = (c == CH_STAR);
    assign is_dot  = (c == CH_DOT);
    assign is_flag = (c == CH_MINUS) || (c == CH_PLUS) || (c == CH_SPACE) ||
                     (c == CH_HASH) || (c == CH_ZERO);

    // Walk the phase for this character
    always_comb
    begin
        s          = cur;
        do_len     = 1'b0;
        do_consume = 1'b0;
        emit       = 1'b0;
        len        = LEN_NONE;

        // Open a fresh specifier, dropping any open one
        if (din.start_spec)
        begin
            s.flags     = '0;
            s.width_acc = '0;
            s.prec_acc  = '0;
            s.sd        = '0;
            s.count     = '0;
            s.phase     = PH_FLAGS;
        end

        unique case (s.phase)
            PH_IDLE:
            begin
                s.phase = PH_IDLE;
            end
            PH_FLAGS, PH_WIDTH:
            begin
                priority if (s.phase == PH_FLAGS && is_flag)
                begin
                    s.flags[FLG_MINUS] = s.flags[FLG_MINUS] | (c == CH_MINUS);
                    s.flags[FLG_PLUS]  = s.flags[FLG_PLUS]  | (c == CH_PLUS);
                    s.flags[FLG_SPACE] = s.flags[FLG_SPACE] | (c == CH_SPACE);
                    s.flags[FLG_HASH]  = s.flags[FLG_HASH]  | (c == CH_HASH);
                    s.flags[FLG_ZERO]  = s.flags[FLG_ZERO]  | (c == CH_ZERO);
                    do_consume = 1'b1;
                end
                else if (s.sd.wstar && (is_dig || is_star))
                begin
                    do_consume = 1'b1;
                    s.phase    = PH_SKIP;
                end
                else if (!s.sd.wstar && is_dig)
                begin
                    s.width_acc = acc_digit(s.width_acc, c);
                    do_consume  = 1'b1;
                    s.phase     = PH_WIDTH;
                end
                else if (!s.sd.wstar && is_star)
                begin
                    s.sd.wstar = 1'b1;
                    do_consume = 1'b1;
                    s.phase    = PH_WIDTH;
                end
                else if (is_dot)
                begin
                    s.sd.dot   = 1'b1;
                    do_consume = 1'b1;
                    s.phase    = PH_PREC_FIRST;
                end
                else
                begin
                    do_len = 1'b1;
                end
            end
            PH_PREC_FIRST, PH_PREC_DIGITS:
            begin
                priority if (s.phase == PH_PREC_FIRST && is_star)
                begin
                    s.sd.pstar = 1'b1;
                    do_consume = 1'b1;
                    s.phase    = PH_SKIP;
                end
                else if (is_dig)
                begin
                    s.prec_acc = acc_digit(s.prec_acc, c);
                    do_consume = 1'b1;
                    s.phase    = PH_PREC_DIGITS;
                end
                else if (is_dot || is_star)
                begin
                    do_consume = 1'b1;
                    s.phase    = PH_SKIP;
                end
                else
                begin
                    do_len = 1'b1;
                end
            end
            PH_SKIP:
            begin
                if (is_dig || is_dot || is_star)
                    do_consume = 1'b1;
                else
                    do_len = 1'b1;
            end
            PH_H_PEND:
            begin
                emit       = 1'b1;
                do_consume = (c == CH_H);
                len        = (c == CH_H) ? LEN_HH : LEN_H;
            end
            PH_L_PEND:
            begin
                emit       = 1'b1;
                do_consume = (c == CH_L);
                len        = (c == CH_L) ? LEN_LL : LEN_L;
            end
        endcase

        // Length modifier or ending character
        if (do_len)
        begin
            priority if (c == CH_H)
            begin
                do_consume = 1'b1;
                s.phase    = PH_H_PEND;
            end
            else if (c == CH_L)
            begin
                do_consume = 1'b1;
                s.phase    = PH_L_PEND;
            end
            else if (c == CH_J)
            begin
                do_consume = 1'b1;
                emit       = 1'b1;
                len        = LEN_J;
            end
            else if (c == CH_Z)
            begin
                do_consume = 1'b1;
                emit       = 1'b1;
                len        = LEN_Z;
            end
            else if (c == CH_T)
            begin
                do_consume = 1'b1;
                emit       = 1'b1;
                len        = LEN_T;
            end
            else
            begin
                emit = 1'b1;
                len  = LEN_NONE;
            end
        end

        // Count the character, saturating
        if (do_consume && (s.count != OUT_MAX))
            s.count = s.count + OUT_W'(1);

        if (emit)
            s.phase = PH_IDLE;
    end

    // Assemble the result from the updated state
    always_comb
    begin
        res.left_align         = s.flags[FLG_MINUS];
        res.force_sign         = s.flags[FLG_PLUS];
        res.space_sign         = s.flags[FLG_SPACE];
        res.alt_form           = s.flags[FLG_HASH];
        res.zero_pad           = s.flags[FLG_ZERO];
        res.field_width        = clip_num(s.width_acc);
        res.width_from_arg     = s.sd.wstar;
        res.has_precision      = s.sd.dot;
        res.precision_value    = clip_num(s.prec_acc);
        res.precision_from_arg = s.sd.pstar;
        res.length_code        = len;
        res.chars_consumed     = s.count;
    end

    assign nxt = s;

endmodule

/* design/fsp_out_stage.sv */
// Result register with valid/ready handshake towards the consumer.
module fsp_out_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  fsp_pkg::out_t load_data,
    output logic          can_load,
    output logic          out_valid,
    input  logic          out_ready,
    output fsp_pkg::out_t out_data
);
    import fsp_pkg::*;

    logic valid_reg;
    logic valid_next;
    out_t data_reg;

    // Room when empty or when the held result leaves this cycle
    assign can_load = !valid_reg || out_ready;

    // Set on load, clear on transfer
    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Hold payload until replaced
    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= load_data;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* design/format_spec_parser_core.sv */
// Top level of the printf-style conversion specifier parser.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------
//  in      | sink      | in_valid / in_ready    | in_data  (ch, start_spec)
//  out     | source    | out_valid / out_ready  | out_data (flags, width, ...)
//
//  One character is taken per cycle while in_ready is high; the parser state
//  updates at the edge that takes it, and a finished specifier lands in the
//  result register at that same edge and shows on out_valid in the following cycle.
//  in_ready is low only while the result register is full and out_ready is low.
//  Reset clears the parser state to idle and empties the result register.
module format_spec_parser_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  fsp_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output fsp_pkg::out_t out_data
);
    import fsp_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;
    logic   emit;
    logic   can_load;
    out_t   res;

    assign in_ready = can_load;
    assign accept   = in_valid && in_ready;

    // Next state and result for the presented character
    fsp_step u_step (
        .cur  (state_reg),
        .din  (in_data),
        .nxt  (state_next),
        .emit (emit),
        .res  (res)
    );

    // Advance the parser on each input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase     <= PH_IDLE;
            state_reg.flags     <= '0;
            state_reg.width_acc <= '0;
            state_reg.prec_acc  <= '0;
            state_reg.sd        <= '0;
            state_reg.count     <= '0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    fsp_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept && emit),
        .load_data (res),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // A new result only follows an input transfer
    a_rise_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(accept))
        else $error("result appeared without an input transfer");

    // A started specifier that does not end at once stays open
    a_start_opens: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_data.start_spec && !emit) |=> (state_reg.phase != PH_IDLE))
        else $error("specifier not opened on start");

    // A pending length modifier has been counted
    a_pend_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase == PH_H_PEND || state_reg.phase == PH_L_PEND)
        |-> (state_reg.count != '0))
        else $error("pending length modifier without a counted character");

    // The precision phase is only reached through a dot
    a_prec_dot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase == PH_PREC_FIRST || state_reg.phase == PH_PREC_DIGITS)
        |-> state_reg.sd.dot)
        else $error("precision phase without a dot");

endmodule

/* tb/format_spec_parser_checker.sv */
// Checker for the format specifier parser: predicts each specifier and compares results.
`timescale 1ns / 100ps

module format_spec_parser_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          in_ready,
    input  fsp_pkg::in_t  in_data,
    input  logic          out_valid,
    input  logic          out_ready,
    input  fsp_pkg::out_t out_data,
    output int            fail_count,
    output int            pending
);

    import fsp_pkg::*;

    // Parser state as predicted from the accepted characters
    phase_t               spec_phase;
    logic [4:0]           spec_flags;
    logic [NUM_WIDTH-1:0] spec_width;
    logic [NUM_WIDTH-1:0] spec_prec;
    sd_t                  spec_marks;
    logic [OUT_W-1:0]     spec_count;

    // Specifiers parsed but not yet seen on the result channel
    out_t expected_specs[$];

    function automatic logic is_digit(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    // Append one decimal digit, holding at the accumulator maximum
    function automatic logic [NUM_WIDTH-1:0] add_digit(logic [NUM_WIDTH-1:0] acc,
                                                       logic [7:0] c);
        longint unsigned top_value;
        longint unsigned v;
        top_value = (64'd1 << NUM_WIDTH) - 64'd1;
        v = 64'(acc) * 64'd10 + 64'(c - CH_ZERO);
        if (v > top_value)
            return '1;
        return v[NUM_WIDTH-1:0];
    endfunction

    // Clip an accumulator to the reported width
    function automatic logic [OUT_W-1:0] to_report(logic [NUM_WIDTH-1:0] v);
        if (64'(v) > 64'(OUT_MAX))
            return OUT_MAX;
        return OUT_W'(v);
    endfunction

    task automatic count_char();
        if (spec_count != OUT_MAX)
            spec_count++;
    endtask

    task automatic clear_spec();
        spec_flags = '0;
        spec_width = '0;
        spec_prec  = '0;
        spec_marks = '0;
        spec_count = '0;
    endtask

    // Advance the parser by one character; queue the specifier when it closes
    task automatic parse_char(in_t item);
        logic [7:0] c;
        logic       taken;
        logic       closed;
        logic [2:0] len;
        out_t       spec;
        c      = item.ch;
        taken  = 1'b0;
        closed = 1'b0;
        len    = LEN_NONE;
        if (item.start_spec)
        begin
            clear_spec();
            spec_phase = PH_FLAGS;
        end
        case (spec_phase)
            PH_IDLE:
                taken = 1'b1;
            PH_FLAGS, PH_WIDTH:
            begin
                // a flag only counts while still in the flag run
                if (spec_phase == PH_FLAGS && (c == CH_MINUS || c == CH_PLUS ||
                    c == CH_SPACE || c == CH_HASH || c == CH_ZERO))
                begin
                    case (c)
                        CH_MINUS: spec_flags[FLG_MINUS] = 1'b1;
                        CH_PLUS:  spec_flags[FLG_PLUS]  = 1'b1;
                        CH_SPACE: spec_flags[FLG_SPACE] = 1'b1;
                        CH_HASH:  spec_flags[FLG_HASH]  = 1'b1;
                        default:  spec_flags[FLG_ZERO]  = 1'b1;
                    endcase
                    count_char();
                    taken = 1'b1;
                end
                else if (spec_marks.wstar)
                begin
                    if (is_digit(c) || c == CH_STAR)
                    begin
                        count_char();
                        spec_phase = PH_SKIP;
                        taken = 1'b1;
                    end
                end
                else if (is_digit(c))
                begin
                    spec_width = add_digit(spec_width, c);
                    count_char();
                    spec_phase = PH_WIDTH;
                    taken = 1'b1;
                end
                else if (c == CH_STAR)
                begin
                    spec_marks.wstar = 1'b1;
                    count_char();
                    spec_phase = PH_WIDTH;
                    taken = 1'b1;
                end
                if (!taken && c == CH_DOT)
                begin
                    spec_marks.dot = 1'b1;
                    count_char();
                    spec_phase = PH_PREC_FIRST;
                    taken = 1'b1;
                end
            end
            PH_PREC_FIRST, PH_PREC_DIGITS:
            begin
                if (spec_phase == PH_PREC_FIRST && c == CH_STAR)
                begin
                    spec_marks.pstar = 1'b1;
                    count_char();
                    spec_phase = PH_SKIP;
                    taken = 1'b1;
                end
                else if (is_digit(c))
                begin
                    spec_prec = add_digit(spec_prec, c);
                    count_char();
                    spec_phase = PH_PREC_DIGITS;
                    taken = 1'b1;
                end
                else if (c == CH_DOT || c == CH_STAR)
                begin
                    count_char();
                    spec_phase = PH_SKIP;
                    taken = 1'b1;
                end
            end
            PH_SKIP:
                if (is_digit(c) || c == CH_DOT || c == CH_STAR)
                begin
                    count_char();
                    taken = 1'b1;
                end
            PH_H_PEND:
            begin
                // a second h is part of the specifier, anything else is not
                if (c == CH_H)
                begin
                    count_char();
                    len = LEN_HH;
                end
                else
                    len = LEN_H;
                closed = 1'b1;
                taken  = 1'b1;
            end
            PH_L_PEND:
            begin
                if (c == CH_L)
                begin
                    count_char();
                    len = LEN_LL;
                end
                else
                    len = LEN_L;
                closed = 1'b1;
                taken  = 1'b1;
            end
            default:
                taken = 1'b1;
        endcase

        // length modifier or ending character
        if (!taken)
        begin
            case (c)
                CH_H:
                begin
                    count_char();
                    spec_phase = PH_H_PEND;
                end
                CH_L:
                begin
                    count_char();
                    spec_phase = PH_L_PEND;
                end
                CH_J:
                begin
                    count_char();
                    len = LEN_J;
                    closed = 1'b1;
                end
                CH_Z:
                begin
                    count_char();
                    len = LEN_Z;
                    closed = 1'b1;
                end
                CH_T:
                begin
                    count_char();
                    len = LEN_T;
                    closed = 1'b1;
                end
                default:
                    closed = 1'b1;
            endcase
        end

        if (closed)
        begin
            spec.left_align         = spec_flags[FLG_MINUS];
            spec.force_sign         = spec_flags[FLG_PLUS];
            spec.space_sign         = spec_flags[FLG_SPACE];
            spec.alt_form           = spec_flags[FLG_HASH];
            spec.zero_pad           = spec_flags[FLG_ZERO];
            spec.field_width        = to_report(spec_width);
            spec.width_from_arg     = spec_marks.wstar;
            spec.has_precision      = spec_marks.dot;
            spec.precision_value    = to_report(spec_prec);
            spec.precision_from_arg = spec_marks.pstar;
            spec.length_code        = len;
            spec.chars_consumed     = spec_count;
            expected_specs.push_back(spec);
            spec_phase = PH_IDLE;
        end
    endtask

    task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            fail_count++;
        end
    endtask

    // Compare each result transfer with the oldest specifier, then predict
    always @(posedge clk or negedge rst_n)
    begin
        out_t want;
        if (!rst_n)
        begin
            spec_phase = PH_IDLE;
            clear_spec();
            expected_specs.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_specs.size() == 0)
                begin
                    $display("%0t: result transfer with no specifier waiting, got %h",
                             $time, out_data);
                    fail_count++;
                end
                else
                begin
                    want = expected_specs.pop_front();
                    check_field("left_align", 32'(want.left_align),
                                32'(out_data.left_align));
                    check_field("force_sign", 32'(want.force_sign),
                                32'(out_data.force_sign));
                    check_field("space_sign", 32'(want.space_sign),
                                32'(out_data.space_sign));
                    check_field("alt_form", 32'(want.alt_form),
                                32'(out_data.alt_form));
                    check_field("zero_pad", 32'(want.zero_pad),
                                32'(out_data.zero_pad));
                    check_field("field_width", 32'(want.field_width),
                                32'(out_data.field_width));
                    check_field("width_from_arg", 32'(want.width_from_arg),
                                32'(out_data.width_from_arg));
                    check_field("has_precision", 32'(want.has_precision),
                                32'(out_data.has_precision));
                    check_field("precision_value", 32'(want.precision_value),
                                32'(out_data.precision_value));
                    check_field("precision_from_arg", 32'(want.precision_from_arg),
                                32'(out_data.precision_from_arg));
                    check_field("length_code", 32'(want.length_code),
                                32'(out_data.length_code));
                    check_field("chars_consumed", 32'(want.chars_consumed),
                                32'(out_data.chars_consumed));
                end
            end
            if (in_valid && in_ready)
                parse_char(in_data);
        end
        pending = expected_specs.size();
    end

endmodule

/* tb/format_spec_parser_core_tb.sv */
// Testbench top for the format specifier parser: stimulus, back-pressure and verdict.
`timescale 1ns / 100ps

module format_spec_parser_core_tb;

    import fsp_pkg::*;

    localparam int STALL_LIMIT     = 2000;
    localparam int RANDOM_CHARS    = 1500;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int HOLD_OFF_AFTER  = 300;

    typedef enum int {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_COIN} rx_mode_t;

    logic  clk = 1'b0;
    logic  rst_n;
    logic  in_valid;
    logic  in_ready;
    in_t   in_data;
    logic  out_valid;
    logic  out_ready;
    out_t  out_data;
    int    fail_count;
    int    pending;

    int    burst_left;
    int    spec_chars;
    logic  spec_open;

    always #1 clk = ~clk;

    format_spec_parser_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    format_spec_parser_checker checker_inst (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Offer one character and hold it until the transfer; called at a falling edge
    task automatic send_char(logic [7:0] c, logic start);
        int gap;
        in_data.ch         = c;
        in_data.start_spec = start;
        in_valid           = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        // close the burst with a random gap
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 10);
            if (gap > 0)
            begin
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? 200 : $urandom_range(1, 40);
        end
    endtask

    // Send one character of a specifier, marking the first one
    task automatic spec_char(logic [7:0] c);
        send_char(c, spec_open);
        spec_open = 1'b0;
        spec_chars++;
    endtask

    task automatic send_spec(string s);
        spec_open = 1'b1;
        for (int i = 0; i < s.len(); i++)
            spec_char(s[i]);
    endtask

    task automatic send_digits(int n);
        repeat (n) spec_char(CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    // Well-formed specifier with random content
    task automatic send_random_spec();
        string flag_set;
        string skip_set;
        string conv_set;
        int    pick;
        flag_set  = "-+ #0";
        skip_set  = ".*0123456789";
        conv_set  = "diouxXcspfeg%";
        spec_open = 1'b1;

        repeat ($urandom_range(0, 3)) spec_char(flag_set[$urandom_range(0, 4)]);

        // width: none, short, long enough to saturate, or star
        pick = $urandom_range(0, 9);
        if (pick >= 3 && pick <= 6)
            send_digits($urandom_range(1, 2));
        else if (pick == 7)
            send_digits($urandom_range(5, 7));
        else if (pick >= 8)
            spec_char(CH_STAR);

        // precision
        if ($urandom_range(0, 9) >= 4)
        begin
            spec_char(CH_DOT);
            pick = $urandom_range(0, 5);
            if (pick >= 1 && pick <= 3)
                send_digits($urandom_range(1, 3));
            else if (pick == 4)
                spec_char(CH_STAR);
            else if (pick == 5)
                send_digits($urandom_range(5, 7));
        end

        // stray digits, dots and stars
        if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 3)) spec_char(skip_set[$urandom_range(0, 11)]);

        case (3'($urandom_range(0, 7)))
            LEN_HH:
            begin
                spec_char(CH_H);
                spec_char(CH_H);
            end
            LEN_H:  spec_char(CH_H);
            LEN_LL:
            begin
                spec_char(CH_L);
                spec_char(CH_L);
            end
            LEN_L:  spec_char(CH_L);
            LEN_J:  spec_char(CH_J);
            LEN_Z:  spec_char(CH_Z);
            LEN_T:  spec_char(CH_T);
            default: ;
        endcase

        // conversion character, sometimes left out so the next specifier restarts
        if (spec_open || $urandom_range(0, 7) != 0)
            spec_char(conv_set[$urandom_range(0, conv_set.len() - 1)]);
    endtask

    // Receiver: random stall pattern, one long hold-off once traffic is under way
    initial
    begin : receiver
        int       seg_len;
        rx_mode_t mode;
        logic     held;
        out_ready = 1'b0;
        held      = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!held && spec_chars >= HOLD_OFF_AFTER)
            begin
                held = 1'b1;
                @(negedge clk);
                out_ready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end
            seg_len = $urandom_range(10, 150);
            mode    = rx_mode_t'($urandom_range(0, 3));
            repeat (seg_len)
            begin
                @(negedge clk);
                case (mode)
                    RX_OPEN:   out_ready = 1'b1;
                    RX_MOSTLY: out_ready = ($urandom_range(0, 3) != 0);
                    RX_SPARSE: out_ready = ($urandom_range(0, 3) == 0);
                    default:   out_ready = 1'($urandom_range(0, 1));
                endcase
            end
        end
    end

    // Watchdog: end the run when nothing transfers for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("** format_spec_parser_core: FAILED **");
        $finish;
    end

    // Stimulus and verdict
    initial
    begin : stimulus
        int n;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        burst_left = 1;
        spec_chars = 0;
        spec_open  = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // all flags, zero as flag then as width digit, precision, hh
        send_spec("-+ #010.5hhd");
        // star width followed by digits and a late dot, then l
        send_spec("*7.3ld");
        // star precision, ll
        send_spec(".*llx");
        // saturating width and precision, z
        send_spec("70000.99999z");
        // single h ended by another character, then j and t alone
        send_spec("hx");
        send_spec("j");
        send_spec("t");
        // open a specifier and restart it on a zero byte
        send_spec("5");
        send_char(8'h00, 1'b1);
        send_char(8'hFF, 1'b0);

        while (spec_chars < RANDOM_CHARS)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                // noise: raw bytes with random start marks
                n = $urandom_range(1, 6);
                repeat (n) send_char(8'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0));
                spec_chars += n;
            end
            else
            begin
                send_random_spec();
                repeat ($urandom_range(0, 2)) send_char(8'($urandom_range(0, 255)), 1'b0);
            end
        end
        in_valid = 1'b0;

        // drain outstanding specifiers, then allow for late stray results
        wait (pending == 0);
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("** format_spec_parser_core: PASSED **");
        else
            $display("** format_spec_parser_core: FAILED **");
        $finish;
    end

endmodule

/* format_spec_parser_core.f */
design/fsp_pkg.sv
design/fsp_step.sv
design/fsp_out_stage.sv
design/format_spec_parser_core.sv
tb/format_spec_parser_checker.sv
tb/format_spec_parser_core_tb.sv
